// ===== hw/rtl/pbfc_pkg.sv =====
// Shared constants and helper functions for the pendulum balance force controller.
package pbfc_pkg;

  localparam logic [33:0] PI30      = 34'd3373259426;
  localparam logic [33:0] TWO_PI30  = 34'd6746518852;
  localparam logic [31:0] HALF_PI30 = 32'd1686629713;
  localparam logic signed [63:0] ONE30 = 64'sd1073741824;
  localparam logic signed [63:0] SMAX  = 64'sh7FFF_FFFF_FFFF_FFFF;

  localparam int FMUL_LAT = 3;

  localparam logic [3:0] REG_CART_MASS   = 4'd0;
  localparam logic [3:0] REG_BOB_MASS    = 4'd1;
  localparam logic [3:0] REG_ARM_LENGTH  = 4'd2;
  localparam logic [3:0] REG_ARM_INERTIA = 4'd3;
  localparam logic [3:0] REG_GRAV_ACCEL  = 4'd4;
  localparam logic [3:0] REG_ANGLE_GAIN  = 4'd5;
  localparam logic [3:0] REG_RATE_GAIN   = 4'd6;
  localparam logic [3:0] REG_FORCE_LIMIT = 4'd7;

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s > 65'(SMAX)) begin
      return SMAX;
    end else if (s < -65'(SMAX)) begin
      return -SMAX;
    end
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    s = 65'(a) - 65'(b);
    if (s > 65'(SMAX)) begin
      return SMAX;
    end else if (s < -65'(SMAX)) begin
      return -SMAX;
    end
    return s[63:0];
  endfunction

  // reciprocal ceil(2^shift / c) for exact division of 35-bit magnitudes
  function automatic logic [35:0] recip_of(input int c);
    case (c)
      182:     return 36'd48330181441;
      156:     return 36'd56385211681;
      132:     return 36'd66637068351;
      110:     return 36'd39982241011;
      90:      return 36'd48867183457;
      72:      return 36'd61083979321;
      56:      return 36'd39268272421;
      42:      return 36'd52357696561;
      30:      return 36'd36650387593;
      20:      return 36'd54975581389;
      12:      return 36'd45812984491;
      6:       return 36'd45812984491;
      2:       return 36'd34359738368;
      default: return 36'd0;
    endcase
  endfunction

  function automatic int rshift_of(input int c);
    case (c)
      182, 156, 132: return 43;
      110, 90, 72:   return 42;
      56, 42:        return 41;
      30, 20:        return 40;
      12:            return 39;
      6:             return 38;
      2:             return 36;
      default:       return 35;
    endcase
  endfunction

endpackage

// ===== hw/rtl/pbfc_delay.sv =====
// Enabled shift-register delay line.
module pbfc_delay #(
  parameter int W = 64,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] sr [0:N-1];

  always_ff @(posedge clk) begin
    if (en) begin
      sr[0] <= d;
      for (int i = 1; i < N; i++) begin
        sr[i] <= sr[i-1];
      end
    end
  end

  assign q = sr[N-1];

endmodule

// ===== hw/rtl/pbfc_fmul.sv =====
// Three-stage signed fixed-point multiplier with rounding and saturation.
module pbfc_fmul #(
  parameter int SH = 32
) (
  input  logic               clk,
  input  logic               en,
  input  logic signed [63:0] a,
  input  logic signed [63:0] b,
  output logic signed [63:0] p
);

  localparam logic [62:0] SMAX_MAG = pbfc_pkg::SMAX[62:0];

  logic [63:0]  am;
  logic [63:0]  bm;
  logic [63:0]  p00;
  logic [63:0]  p01;
  logic [63:0]  p10;
  logic [63:0]  p11;
  logic         neg1;
  logic [127:0] sum;
  logic         neg2;
  logic [127:0] rnd;
  logic [127:0] shr;
  logic [62:0]  mag;

  assign am = a[63] ? 64'(-a) : 64'(a);
  assign bm = b[63] ? 64'(-b) : 64'(b);

  always_ff @(posedge clk) begin
    if (en) begin
      p00  <= 64'(am[31:0]) * 64'(bm[31:0]);
      p01  <= 64'(am[31:0]) * 64'(bm[63:32]);
      p10  <= 64'(am[63:32]) * 64'(bm[31:0]);
      p11  <= 64'(am[63:32]) * 64'(bm[63:32]);
      neg1 <= a[63] ^ b[63];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum  <= {64'd0, p00} + ({64'd0, p01} << 32) + ({64'd0, p10} << 32) + {p11, 64'd0};
      neg2 <= neg1;
    end
  end

  always_comb begin
    rnd = sum + (128'd1 << (SH - 1));
    shr = rnd >> SH;
    mag = (|shr[127:63]) ? SMAX_MAG : shr[62:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p <= neg2 ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end
  end

endmodule

// ===== hw/rtl/pbfc_poly.sv =====
// Pipelined nested-product sine or cosine series in Q30.
module pbfc_poly #(
  parameter int NITER     = 6,
  parameter int FIRST_N   = 12,
  parameter bit FINAL_MUL = 1'b1
) (
  input  logic               clk,
  input  logic               en,
  input  logic signed [63:0] x,
  output logic signed [63:0] y
);

  localparam int ILAT = pbfc_pkg::FMUL_LAT + 2;

  logic signed [63:0] x2;
  logic signed [63:0] x2_d [0:NITER-1];
  logic signed [63:0] t    [0:NITER];

  pbfc_fmul #(.SH(30)) u_sq (.clk(clk), .en(en), .a(x), .b(x), .p(x2));

  assign t[0] = pbfc_pkg::ONE30;

  for (genvar i = 0; i < NITER; i++) begin : g_iter
    localparam int NN = FIRST_N - 2 * i;
    localparam int CC = NN * (NN + 1);
    localparam logic [35:0] RC = pbfc_pkg::recip_of(CC);
    localparam int SC = pbfc_pkg::rshift_of(CC);

    logic signed [63:0] ym;
    logic [34:0]        mm;
    logic [70:0]        prod;
    logic               neg;
    logic [63:0]        qv;
    logic signed [63:0] tn;

    if (i == 0) begin : g_first
      assign x2_d[0] = x2;
    end else begin : g_next
      pbfc_delay #(.W(64), .N(ILAT)) u_x2d (
        .clk(clk), .en(en), .d(x2_d[i-1]), .q(x2_d[i])
      );
    end

    pbfc_fmul #(.SH(30)) u_mul (.clk(clk), .en(en), .a(x2_d[i]), .b(t[i]), .p(ym));

    assign mm = ym[63] ? 35'(-ym) : 35'(ym);
    assign qv = 64'(prod >> SC);

    always_ff @(posedge clk) begin
      if (en) begin
        prod <= 71'(mm) * 71'(RC);
        neg  <= ym[63];
        tn   <= pbfc_pkg::ONE30 - (neg ? -$signed(qv) : $signed(qv));
      end
    end

    assign t[i+1] = tn;
  end

  if (FINAL_MUL) begin : g_sin
    logic signed [63:0] xd;
    pbfc_delay #(.W(64), .N(pbfc_pkg::FMUL_LAT + NITER * ILAT)) u_xd (
      .clk(clk), .en(en), .d(x), .q(xd)
    );
    pbfc_fmul #(.SH(30)) u_fin (.clk(clk), .en(en), .a(xd), .b(t[NITER]), .p(y));
  end else begin : g_cos
    assign y = t[NITER];
  end

endmodule

// ===== hw/rtl/pbfc_div.sv =====
// Saturating restoring divider stages for the final force quotient.
module pbfc_div (
  input  logic               clk,
  input  logic               en,
  input  logic signed [63:0] num,
  input  logic signed [63:0] b,
  input  logic [30:0]        lim,
  output logic signed [31:0] force_q
);

  localparam int QB = 31;

  typedef struct packed {
    logic sgn;
    logic nz;
    logic sat;
  } ctl_t;

  logic [63:0] nm1;
  logic [63:0] bm1;
  logic        sgn1;
  logic        nz1;
  logic        bz1;
  logic [62:0] pl2;
  logic [62:0] ph2;
  logic [63:0] nm2;
  logic [63:0] bm2;
  logic        sgn2;
  logic        nz2;
  logic        bz2;
  logic [94:0] lb;
  logic [79:0] n16;

  logic [95:0]   rem [0:QB];
  logic [QB-1:0] qs  [0:QB];
  logic [63:0]   bms [0:QB];
  ctl_t          cs  [0:QB];

  logic [30:0] qq;

  always_ff @(posedge clk) begin
    if (en) begin
      nm1  <= num[63] ? 64'(-num) : 64'(num);
      bm1  <= b[63] ? 64'(-b) : 64'(b);
      sgn1 <= num[63] ^ b[63];
      nz1  <= (num == 64'sd0);
      bz1  <= (b == 64'sd0);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pl2  <= 63'(lim) * 63'(bm1[31:0]);
      ph2  <= 63'(lim) * 63'(bm1[63:32]);
      nm2  <= nm1;
      bm2  <= bm1;
      sgn2 <= sgn1;
      nz2  <= nz1;
      bz2  <= bz1;
    end
  end

  assign lb  = {ph2, 32'd0} + 95'(pl2);
  assign n16 = {nm2, 16'd0};

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]    <= 96'(n16);
      qs[0]     <= '0;
      bms[0]    <= bm2;
      cs[0].sgn <= sgn2;
      cs[0].nz  <= nz2;
      cs[0].sat <= bz2 | (95'(n16) >= lb);
    end
  end

  for (genvar s = 0; s < QB; s++) begin : g_step
    localparam int BIT = QB - 1 - s;
    logic [95:0] tv;
    assign tv = 96'(bms[s]) << BIT;

    always_ff @(posedge clk) begin
      if (en) begin
        if (rem[s] >= tv) begin
          rem[s+1] <= rem[s] - tv;
          qs[s+1]  <= qs[s] | (QB'(1) << BIT);
        end else begin
          rem[s+1] <= rem[s];
          qs[s+1]  <= qs[s];
        end
        bms[s+1] <= bms[s];
        cs[s+1]  <= cs[s];
      end
    end
  end

  assign qq = cs[QB].sat ? lim : qs[QB];

  always_ff @(posedge clk) begin
    if (en) begin
      if (cs[QB].nz) begin
        force_q <= 32'sd0;
      end else if (cs[QB].sgn) begin
        force_q <= -$signed({1'b0, qq});
      end else begin
        force_q <= $signed({1'b0, qq});
      end
    end
  end

endmodule

// ===== hw/rtl/pendulum_balance_force_controller.sv =====
// Top level of the pendulum balance force controller.
// Pipeline: an item passes through an 87-stage pipeline before its result leaves.
// Throughput: one item per cycle; every stage advances together and halts while the
// output register holds an item that is stalled.
// Reset: rst clears all valid bits and loads the register defaults; pipeline data is
// not cleared.
module pendulum_balance_force_controller (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [3:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               angle_valid,
  output logic               angle_stall,
  input  logic signed [31:0] bob_angle,
  input  logic signed [31:0] bob_rate,
  output logic               force_valid,
  input  logic               force_stall,
  output logic signed [31:0] cart_force
);

  localparam int LAT = 86;

  logic [31:0] cart_mass;
  logic [31:0] bob_mass;
  logic [31:0] arm_length;
  logic [31:0] arm_inertia;
  logic [31:0] grav_accel;
  logic [31:0] angle_gain;
  logic [31:0] rate_gain;
  logic [30:0] force_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      cart_mass   <= 32'd65536;
      bob_mass    <= 32'd65536;
      arm_length  <= 32'd65536;
      arm_inertia <= 32'd0;
      grav_accel  <= 32'd642908;
      angle_gain  <= 32'd0;
      rate_gain   <= 32'd0;
      force_limit <= 31'd655360;
    end else if (cfg_write) begin
      unique case (cfg_index)
        pbfc_pkg::REG_CART_MASS:   cart_mass   <= cfg_data;
        pbfc_pkg::REG_BOB_MASS:    bob_mass    <= cfg_data;
        pbfc_pkg::REG_ARM_LENGTH:  arm_length  <= cfg_data;
        pbfc_pkg::REG_ARM_INERTIA: arm_inertia <= cfg_data;
        pbfc_pkg::REG_GRAV_ACCEL:  grav_accel  <= cfg_data;
        pbfc_pkg::REG_ANGLE_GAIN:  angle_gain  <= cfg_data;
        pbfc_pkg::REG_RATE_GAIN:   rate_gain   <= cfg_data;
        pbfc_pkg::REG_FORCE_LIMIT: force_limit <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  logic signed [63:0] mc, mp, len, inr, grv, kp, kd;
  assign mc  = $signed({16'd0, cart_mass, 16'd0});
  assign mp  = $signed({16'd0, bob_mass, 16'd0});
  assign len = $signed({16'd0, arm_length, 16'd0});
  assign inr = $signed({16'd0, arm_inertia, 16'd0});
  assign grv = $signed({16'd0, grav_accel, 16'd0});
  assign kp  = $signed({16'd0, angle_gain, 16'd0});
  assign kd  = $signed({16'd0, rate_gain, 16'd0});

  logic           advance;
  logic [LAT:0]   v;

  assign advance     = !v[LAT] || !force_stall;
  assign angle_stall = !advance;
  assign force_valid = v[LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (advance) begin
      v <= {v[LAT-1:0], angle_valid};
    end
  end

  logic signed [31:0] ang_r;
  logic signed [31:0] rate_r;

  always_ff @(posedge clk) begin
    if (advance) begin
      ang_r  <= bob_angle;
      rate_r <= bob_rate;
    end
  end

  logic [31:0] amag;
  logic [33:0] am;
  logic [33:0] rr;
  logic        kodd;
  logic        refl;
  logic [31:0] xr;

  always_comb begin
    amag = ang_r[31] ? 32'(-ang_r) : 32'(ang_r);
    am   = {amag, 2'b00};
    kodd = 1'b0;
    if (am >= pbfc_pkg::TWO_PI30) begin
      rr = am - pbfc_pkg::TWO_PI30;
    end else if (am >= pbfc_pkg::PI30) begin
      rr   = am - pbfc_pkg::PI30;
      kodd = 1'b1;
    end else begin
      rr = am;
    end
    refl = (rr[31:0] > pbfc_pkg::HALF_PI30);
    xr   = refl ? 32'(pbfc_pkg::PI30 - rr) : rr[31:0];
  end

  logic signed [63:0] e_r;
  logic signed [63:0] x_r;
  logic               sneg_r;
  logic               cneg_r;
  logic signed [63:0] a_r;

  always_ff @(posedge clk) begin
    if (advance) begin
      e_r    <= ang_r[31] ? -$signed({30'd0, rr}) : $signed({30'd0, rr});
      x_r    <= $signed({32'd0, xr});
      sneg_r <= ang_r[31] ^ kodd;
      cneg_r <= refl ^ kodd;
      a_r    <= pbfc_pkg::sat_add(mc, mp);
    end
  end

  logic signed [63:0] sv, sv2, cv;
  logic [1:0]         sgn38;

  pbfc_poly #(.NITER(6), .FIRST_N(12), .FINAL_MUL(1'b1)) u_sin (
    .clk(clk), .en(advance), .x(x_r), .y(sv)
  );
  pbfc_poly #(.NITER(7), .FIRST_N(13), .FINAL_MUL(1'b0)) u_cos (
    .clk(clk), .en(advance), .x(x_r), .y(cv)
  );
  pbfc_delay #(.W(64), .N(2)) u_sin_al (.clk(clk), .en(advance), .d(sv), .q(sv2));
  pbfc_delay #(.W(2), .N(38)) u_sgn_d (
    .clk(clk), .en(advance), .d({sneg_r, cneg_r}), .q(sgn38)
  );

  logic signed [63:0] s30, c30;

  always_ff @(posedge clk) begin
    if (advance) begin
      s30 <= sgn38[1] ? -sv2 : sv2;
      c30 <= sgn38[0] ? -cv : cv;
    end
  end

  logic signed [63:0] p1, mg, d1, g1m, d_r, a7, ad, ad46, p1_40, g1_40;
  logic signed [63:0] bq, bb, det_r, gs, a43, ag, ag50, kpe, kdr, kdr4;
  logic signed [63:0] term_r, term47, td, num_r, b51;

  pbfc_fmul #(.SH(32)) u_p1  (.clk(clk), .en(advance), .a(mp), .b(len), .p(p1));
  pbfc_fmul #(.SH(32)) u_mg  (.clk(clk), .en(advance), .a(mp), .b(grv), .p(mg));
  pbfc_fmul #(.SH(32)) u_d1  (.clk(clk), .en(advance), .a(p1), .b(len), .p(d1));
  pbfc_fmul #(.SH(32)) u_g1m (.clk(clk), .en(advance), .a(mg), .b(len), .p(g1m));

  always_ff @(posedge clk) begin
    if (advance) begin
      d_r <= pbfc_pkg::sat_add(d1, inr);
    end
  end

  pbfc_delay #(.W(64), .N(6)) u_a7 (.clk(clk), .en(advance), .d(a_r), .q(a7));
  pbfc_fmul #(.SH(32)) u_ad (.clk(clk), .en(advance), .a(a7), .b(d_r), .p(ad));
  pbfc_delay #(.W(64), .N(36)) u_ad46 (.clk(clk), .en(advance), .d(ad), .q(ad46));
  pbfc_delay #(.W(64), .N(37)) u_p140 (.clk(clk), .en(advance), .d(p1), .q(p1_40));
  pbfc_delay #(.W(64), .N(34)) u_g140 (.clk(clk), .en(advance), .d(g1m), .q(g1_40));

  pbfc_fmul #(.SH(30)) u_b  (.clk(clk), .en(advance), .a(p1_40), .b(c30), .p(bq));
  pbfc_fmul #(.SH(32)) u_bb (.clk(clk), .en(advance), .a(bq), .b(bq), .p(bb));

  always_ff @(posedge clk) begin
    if (advance) begin
      det_r <= pbfc_pkg::sat_sub(ad46, bb);
    end
  end

  pbfc_fmul #(.SH(30)) u_gs (.clk(clk), .en(advance), .a(g1_40), .b(s30), .p(gs));
  pbfc_delay #(.W(64), .N(42)) u_a43 (.clk(clk), .en(advance), .d(a_r), .q(a43));
  pbfc_fmul #(.SH(32)) u_ag (.clk(clk), .en(advance), .a(a43), .b(-gs), .p(ag));
  pbfc_delay #(.W(64), .N(4)) u_ag50 (.clk(clk), .en(advance), .d(ag), .q(ag50));

  pbfc_fmul #(.SH(30)) u_kpe (.clk(clk), .en(advance), .a(kp), .b(e_r), .p(kpe));
  pbfc_fmul #(.SH(24)) u_kdr (
    .clk(clk), .en(advance), .a(kd), .b(64'(rate_r)), .p(kdr)
  );
  pbfc_delay #(.W(64), .N(1)) u_kdr4 (.clk(clk), .en(advance), .d(kdr), .q(kdr4));

  always_ff @(posedge clk) begin
    if (advance) begin
      term_r <= pbfc_pkg::sat_sub(-kpe, kdr4);
    end
  end

  pbfc_delay #(.W(64), .N(42)) u_t47 (.clk(clk), .en(advance), .d(term_r), .q(term47));
  pbfc_fmul #(.SH(32)) u_td (.clk(clk), .en(advance), .a(term47), .b(det_r), .p(td));

  always_ff @(posedge clk) begin
    if (advance) begin
      num_r <= pbfc_pkg::sat_sub(ag50, td);
    end
  end

  pbfc_delay #(.W(64), .N(8)) u_b51 (.clk(clk), .en(advance), .d(bq), .q(b51));

  pbfc_div u_div (
    .clk(clk), .en(advance), .num(num_r), .b(b51), .lim(force_limit), .force_q(cart_force)
  );

`ifndef SYNTH
  a_hold_input: assert property (@(posedge clk)
    force_valid && force_stall |-> angle_stall)
    else $error("input taken while output stalled");

  a_enter: assert property (@(posedge clk) disable iff (rst)
    angle_valid && !angle_stall |=> v[0])
    else $error("accepted item lost at entry");

  a_flow: assert property (@(posedge clk)
    !force_valid |-> !angle_stall)
    else $error("pipeline halted with empty output");
`endif

endmodule

// ===== tb/pendulum_balance_force_controller_tb.sv =====
// Self-checking testbench for the pendulum balance force controller.
`timescale 1ns / 100ps

module pendulum_balance_force_controller_tb;

  localparam logic [3:0] REG_UNUSED = 4'd9;

  typedef struct packed {
    logic signed [31:0] angle;
    logic signed [31:0] rate;
  } sample_t;

  localparam int LATENCY = 87;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_write = 1'b0;
  logic [3:0]         cfg_index = '0;
  logic [31:0]        cfg_data = '0;
  logic               angle_valid = 1'b0;
  logic               angle_stall;
  logic signed [31:0] bob_angle = '0;
  logic signed [31:0] bob_rate = '0;
  logic               force_valid;
  logic               force_stall = 1'b0;
  logic signed [31:0] cart_force;

  logic [31:0] m_cart, m_bob, m_len, m_inr, m_grv, m_kp, m_kd;
  logic [30:0] m_lim;

  sample_t            sample_q[$];
  logic signed [31:0] force_q[$];
  int errors = 0;
  int checked = 0;
  int cycles = 0;
  int hold_req = 0;
  int hold_ack = 0;
  int hold_cnt = 0;
  int send_gap = 0;
  int recv_gap = 0;
  bit quiet = 1'b0;

  pendulum_balance_force_controller u_top (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .angle_valid(angle_valid), .angle_stall(angle_stall),
    .bob_angle(bob_angle), .bob_rate(bob_rate),
    .force_valid(force_valid), .force_stall(force_stall), .cart_force(cart_force)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic signed [63:0] sat_sum(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s > $signed({1'b0, pbfc_pkg::SMAX})) return pbfc_pkg::SMAX;
    if (s < -$signed({1'b0, pbfc_pkg::SMAX})) return -pbfc_pkg::SMAX;
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] qmul(input logic signed [63:0] a,
                                              input logic signed [63:0] b, input int sh);
    logic [63:0]  ma, mb;
    logic [127:0] p;
    logic [63:0]  r;
    ma = a[63] ? 64'(-a) : 64'(a);
    mb = b[63] ? 64'(-b) : 64'(b);
    p = ({64'd0, ma} * {64'd0, mb}) + (128'd1 << (sh - 1));
    p = p >> sh;
    r = (p > {64'd0, pbfc_pkg::SMAX}) ? pbfc_pkg::SMAX : p[63:0];
    return (a[63] != b[63]) ? -$signed(r) : $signed(r);
  endfunction

  function automatic logic signed [63:0] sine30(input logic signed [63:0] x, input bit cosine);
    logic signed [63:0] x2, t, dv;
    int n;
    x2 = qmul(x, x, 30);
    t = pbfc_pkg::ONE30;
    for (n = cosine ? 13 : 12; n >= (cosine ? 1 : 2); n -= 2) begin
      dv = n * (n + 1);
      t = pbfc_pkg::ONE30 - qmul(x2, t, 30) / dv;
    end
    return cosine ? t : qmul(x, t, 30);
  endfunction

  function automatic logic signed [31:0] balance_force(input sample_t s);
    logic [63:0] am, k, r, bm, nm;
    logic [127:0] nw, lw, q;
    logic signed [63:0] e, sv, cv, rate, mc, mp, len, inr, grv, kp, kd;
    logic signed [63:0] a, d, b, det, g1, term, num;
    bit aneg, cflip;
    aneg = s.angle[31];
    am = (aneg ? -64'(s.angle) : 64'(s.angle)) << 2;
    k = am / 64'(pbfc_pkg::PI30);
    r = am - k * 64'(pbfc_pkg::PI30);
    e = aneg ? -$signed(r) : $signed(r);
    cflip = r > 64'(pbfc_pkg::HALF_PI30);
    if (cflip) r = 64'(pbfc_pkg::PI30) - r;
    sv = sine30($signed(r), 1'b0);
    cv = sine30($signed(r), 1'b1);
    if (aneg != k[0]) sv = -sv;
    if (cflip != k[0]) cv = -cv;
    rate = 64'(s.rate);
    mc = 64'(m_cart) << 16;
    mp = 64'(m_bob) << 16;
    len = 64'(m_len) << 16;
    inr = 64'(m_inr) << 16;
    grv = 64'(m_grv) << 16;
    kp = 64'(m_kp) << 16;
    kd = 64'(m_kd) << 16;
    a = sat_sum(mc, mp);
    d = sat_sum(qmul(qmul(mp, len, 32), len, 32), inr);
    b = qmul(qmul(mp, len, 32), cv, 30);
    det = sat_sum(qmul(a, d, 32), -qmul(b, b, 32));
    g1 = -qmul(qmul(qmul(mp, grv, 32), len, 32), sv, 30);
    term = sat_sum(-qmul(kp, e, 30), -qmul(kd, rate, 24));
    num = sat_sum(qmul(a, g1, 32), -qmul(term, det, 32));
    if (num == 0) return 32'sd0;
    bm = b[63] ? 64'(-b) : 64'(b);
    nm = num[63] ? 64'(-num) : 64'(num);
    nw = {64'd0, nm} << 16;
    lw = {97'd0, m_lim} * {64'd0, bm};
    q = (bm == 0 || nw >= lw) ? {97'd0, m_lim} : nw / {64'd0, bm};
    return (num[63] != b[63]) ? -$signed(q[31:0]) : $signed(q[31:0]);
  endfunction

  task automatic write_reg(input logic [3:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      pbfc_pkg::REG_CART_MASS:   m_cart = val;
      pbfc_pkg::REG_BOB_MASS:    m_bob = val;
      pbfc_pkg::REG_ARM_LENGTH:  m_len = val;
      pbfc_pkg::REG_ARM_INERTIA: m_inr = val;
      pbfc_pkg::REG_GRAV_ACCEL:  m_grv = val;
      pbfc_pkg::REG_ANGLE_GAIN:  m_kp = val;
      pbfc_pkg::REG_RATE_GAIN:   m_kd = val;
      pbfc_pkg::REG_FORCE_LIMIT: m_lim = val[30:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic write_all(input logic [31:0] v[8]);
    for (int i = 0; i < 8; i++) write_reg(4'(i), v[i]);
  endtask

  task automatic push(input logic [31:0] ang, input logic [31:0] rt);
    sample_t s;
    s.angle = ang;
    s.rate = rt;
    sample_q.push_back(s);
  endtask

  task automatic push_random(input int n);
    logic [31:0] ang, rt;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 3))
        0: begin
          ang = $urandom;
          rt = $urandom;
        end
        default: begin
          ang = 32'($signed($urandom_range(0, 32'h2000_0000)) - 32'sh1000_0000);
          rt = 32'($signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000);
        end
      endcase
      push(ang, rt);
    end
  endtask

  task automatic drain();
    wait (sample_q.size() == 0 && !angle_valid && force_q.size() == 0);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic random_cfg();
    logic [31:0] v[8];
    for (int i = 0; i < 8; i++) begin
      case ($urandom_range(0, 3))
        0: v[i] = $urandom;
        1: v[i] = $urandom_range(0, 32'h0000_ffff);
        default: v[i] = $urandom_range(32'h0000_4000, 32'h000f_ffff);
      endcase
    end
    write_all(v);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      angle_valid <= 1'b0;
    end else if (!angle_valid || !angle_stall) begin
      if (angle_valid) begin
        sample_t s;
        s.angle = bob_angle;
        s.rate = bob_rate;
        force_q.push_back(balance_force(s));
      end
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        angle_valid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        send_gap <= $urandom_range(0, 11);
        angle_valid <= 1'b0;
      end else if (sample_q.size() > 0) begin
        sample_t s;
        s = sample_q.pop_front();
        angle_valid <= 1'b1;
        bob_angle <= s.angle;
        bob_rate <= s.rate;
      end else begin
        angle_valid <= 1'b0;
      end
    end
  end

  task automatic report_mismatch(input logic signed [31:0] got, input logic signed [31:0] want,
                                 input bit orphan);
    errors++;
    if (errors <= 20) begin
      if (orphan) $display("ERROR: unexpected cart_force %0d", got);
      else $display("ERROR: cart_force %0d, expected %0d", got, want);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      force_stall <= 1'b0;
    end else begin
      if (force_valid && !force_stall) begin
        if (force_q.size() == 0) begin
          report_mismatch(cart_force, '0, 1'b1);
        end else begin
          logic signed [31:0] want;
          want = force_q.pop_front();
          checked++;
          if (cart_force !== want) report_mismatch(cart_force, want, 1'b0);
        end
      end
      if (hold_req != hold_ack) begin
        hold_ack <= hold_req;
        hold_cnt <= HOLD_CYCLES;
        force_stall <= 1'b1;
      end else if (hold_cnt > 0) begin
        hold_cnt <= hold_cnt - 1;
        force_stall <= 1'b1;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        force_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        recv_gap <= $urandom_range(0, 11);
        force_stall <= 1'b1;
      end else begin
        force_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    m_cart = 32'd65536;
    m_bob = 32'd65536;
    m_len = 32'd65536;
    m_inr = 32'd0;
    m_grv = 32'd642908;
    m_kp = 32'd0;
    m_kd = 32'd0;
    m_lim = 31'd655360;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    push(32'd0, 32'd0);
    push(32'h0100_0000, 32'd0);
    drain();

    write_reg(pbfc_pkg::REG_ANGLE_GAIN, 32'h0002_0000);
    write_reg(pbfc_pkg::REG_RATE_GAIN, 32'h0000_8000);
    write_reg(pbfc_pkg::REG_ARM_INERTIA, 32'h0000_1000);
    push(32'd0, 32'd0);
    push(32'h7fff_ffff, 32'd0);
    push(32'h8000_0000, 32'd0);
    push(32'd843314857, 32'd0);
    push(-32'sd843314857, 32'd0);
    push(32'd421657428, 32'h0100_0000);
    push(-32'sd421657428, -32'sh0100_0000);
    push(32'd0, 32'h7fff_ffff);
    push(32'd0, 32'h8000_0000);
    push(32'd1686629713, 32'd1);
    push(32'd1, 32'hffff_ffff);
    push(32'h4000_0000, 32'h1234_5678);
    push(32'hc000_0000, 32'h8765_4321);
    push(32'h0000_1000, 32'd0);
    drain();

    write_reg(pbfc_pkg::REG_BOB_MASS, 32'd0);
    write_reg(REG_UNUSED, 32'hdead_beef);
    push(32'd0, 32'd0);
    push(32'd0, 32'h0100_0000);
    push(32'd0, -32'sh0100_0000);
    push(32'h1000_0000, 32'h0000_0000);
    drain();

    begin
      logic [31:0] v[8];
      v = '{default: 32'hffff_ffff};
      write_all(v);
      push(32'h7fff_ffff, 32'h7fff_ffff);
      push(32'h8000_0000, 32'h8000_0000);
      push_random(80);
      drain();
      v = '{default: 32'd0};
      write_all(v);
      push_random(40);
      drain();
    end

    for (int ph = 0; ph < 4; ph++) begin
      random_cfg();
      if (ph == 1) begin
        hold_req = hold_req + 1;
        push_random(200);
      end else begin
        push_random(100);
      end
      drain();
    end

    begin
      logic [31:0] v[8];
      v = '{32'h0002_0000, 32'h0000_8000, 32'h0000_c000, 32'h0000_0800,
            32'd642908, 32'h0014_0000, 32'h0004_0000, 32'h0064_0000};
      write_all(v);
      quiet = 1'b1;
      push_random(120);
      drain();
    end

    $display("Covered %0d checked forces over directed edges, zero lever, saturated", checked);
    $display("and zeroed settings, random settings, a long output hold and idle-free traffic.");
    if (errors == 0 && force_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
